// ===== hw/rtl/hbd_pkg.sv =====
// Shared types, codes and helpers for the HTTP body dechunker.
// No dependencies; imported by http_body_dechunker_top.
`default_nettype none

package hbd_pkg;

   // Width of the chunk size accumulator
   localparam int SIZE_BITS = 32;

   // Configuration port geometry
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHUNKED_MODE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONTENT_LENGTH = 1'd1;

   // Decoder phases
   localparam logic [3:0] PH_SIZE    = 4'd0;
   localparam logic [3:0] PH_EXT     = 4'd1;
   localparam logic [3:0] PH_DATA    = 4'd2;
   localparam logic [3:0] PH_DATA_CR = 4'd3;
   localparam logic [3:0] PH_DATA_LF = 4'd4;
   localparam logic [3:0] PH_TRAILER = 4'd5;
   localparam logic [3:0] PH_DONE    = 4'd6;
   localparam logic [3:0] PH_ERROR   = 4'd7;

   // Result status codes
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // Framing characters
   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_SEMI = 8'h3b;

   // One result item
   typedef struct packed {
      logic       body_valid;
      logic [7:0] body_byte;
      logic       consumed;
      logic [1:0] status;
   } rsp_type;

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/http_body_dechunker_top.sv =====
// Top level of the HTTP body dechunker: per-byte decode, output register and skid.
// Depends on hbd_pkg.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    data_byte, restart
//   rsp      out        rsp_valid/stall    body_valid, body_byte, consumed, status
//   csr      in         csr_valid/ready    index, data (always ready)
//
// One byte is taken every cycle while req_stall is low; its result is registered
// in the output register, or in the skid when that is full.
// A skid register holds one extra result, so a byte is still taken in the
// cycle rsp first stalls; req_stall rises only once the skid is occupied.
// Reset is synchronous and clears configuration, decoder state and the valid
// flags of both result registers at once; no clearing pass is needed.
`default_nettype none

module http_body_dechunker_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input byte channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_restart,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_body_valid,
   output logic [7:0]                              rsp_body_byte,
   output logic                                    rsp_consumed,
   output logic [1:0]                              rsp_status,
   // configuration channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import hbd_pkg::*;

   // configuration registers
   logic                 chunked_mode_ff;
   logic [31:0]          content_length_ff;

   // decoder state
   logic [3:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] chunk_rem_ff, chunk_rem_in;
   logic [31:0]          length_count_ff, length_count_in;
   logic                 line_empty_ff, line_empty_in;
   logic                 pending_cr_ff, pending_cr_in;

   // state seen by this byte, after an optional restart
   logic [3:0]           phase_cur;
   logic [SIZE_BITS-1:0] chunk_rem_cur;
   logic [31:0]          length_count_cur;
   logic                 line_empty_cur;
   logic                 pending_cr_cur;

   // per-byte result
   logic                 valid_c;
   logic                 cons_c;
   logic [1:0]           status_c;
   logic [4:0]           hex_c;
   logic [SIZE_BITS-1:0] chunk_dec_c;
   rsp_type              result_c;

   // output register and skid
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              skid_ff, skid_in;
   logic                 skid_valid_ff, skid_valid_in;

   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff   <= 1'b0;
         content_length_ff <= 32'd0;
      end else if (csr_xfer) begin
         unique case (csr_index)
            CSR_CHUNKED_MODE:   chunked_mode_ff   <= csr_data[0];
            CSR_CONTENT_LENGTH: content_length_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // apply restart before the byte
   always_comb begin
      if (req_restart) begin
         phase_cur        = PH_SIZE;
         chunk_rem_cur    = '0;
         length_count_cur = 32'd0;
         line_empty_cur   = 1'b1;
         pending_cr_cur   = 1'b0;
      end else begin
         phase_cur        = phase_ff;
         chunk_rem_cur    = chunk_rem_ff;
         length_count_cur = length_count_ff;
         line_empty_cur   = line_empty_ff;
         pending_cr_cur   = pending_cr_ff;
      end
   end

   assign hex_c       = hex_decode(req_data_byte);
   assign chunk_dec_c = chunk_rem_cur - {{(SIZE_BITS-1){1'b0}}, 1'b1};

   // decode one byte
   always_comb begin
      phase_in        = phase_cur;
      chunk_rem_in    = chunk_rem_cur;
      length_count_in = length_count_cur;
      line_empty_in   = line_empty_cur;
      pending_cr_in   = pending_cr_cur;
      valid_c         = 1'b0;
      cons_c          = 1'b1;
      status_c        = ST_BUSY;

      if (!chunked_mode_ff) begin
         // fixed length: count bytes up to content_length
         if (length_count_cur >= content_length_ff) begin
            cons_c   = 1'b0;
            status_c = ST_DONE;
         end else begin
            valid_c         = 1'b1;
            length_count_in = length_count_cur + 32'd1;
            if (length_count_in == content_length_ff) begin
               status_c = ST_DONE;
            end
         end
      end else begin
         unique case (phase_cur)
            PH_SIZE: begin
               if (pending_cr_cur) begin
                  if (req_data_byte == CHAR_LF && !line_empty_cur) begin
                     pending_cr_in = 1'b0;
                     line_empty_in = 1'b1;
                     phase_in      = (chunk_rem_cur == '0) ? PH_TRAILER : PH_DATA;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end else if (req_data_byte == CHAR_CR) begin
                  pending_cr_in = 1'b1;
               end else if (req_data_byte == CHAR_SEMI) begin
                  line_empty_in = 1'b0;
                  phase_in      = PH_EXT;
               end else if (!hex_c[4] || chunk_rem_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                  // non-hex digit or size about to overflow
                  phase_in = PH_ERROR;
               end else begin
                  chunk_rem_in  = {chunk_rem_cur[SIZE_BITS-5:0], hex_c[3:0]};
                  line_empty_in = 1'b0;
               end
            end
            PH_EXT: begin
               if (pending_cr_cur && req_data_byte == CHAR_LF) begin
                  pending_cr_in = 1'b0;
                  line_empty_in = 1'b1;
                  phase_in      = (chunk_rem_cur == '0) ? PH_TRAILER : PH_DATA;
               end else begin
                  pending_cr_in = (req_data_byte == CHAR_CR);
               end
            end
            PH_DATA: begin
               valid_c      = 1'b1;
               chunk_rem_in = chunk_dec_c;
               if (chunk_dec_c == '0) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               phase_in = (req_data_byte == CHAR_CR) ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
               if (req_data_byte == CHAR_LF) begin
                  phase_in      = PH_SIZE;
                  chunk_rem_in  = '0;
                  line_empty_in = 1'b1;
                  pending_cr_in = 1'b0;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_TRAILER: begin
               // skip trailer lines up to an empty one
               if (pending_cr_cur) begin
                  if (req_data_byte == CHAR_LF) begin
                     pending_cr_in = 1'b0;
                     if (line_empty_cur) begin
                        phase_in = PH_DONE;
                     end else begin
                        line_empty_in = 1'b1;
                     end
                  end else begin
                     line_empty_in = 1'b0;
                     pending_cr_in = (req_data_byte == CHAR_CR);
                  end
               end else if (req_data_byte == CHAR_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  line_empty_in = 1'b0;
               end
            end
            PH_DONE: begin
               cons_c = 1'b0;
            end
            default: begin
               // error and unused codes stay in error
               cons_c   = 1'b0;
               phase_in = PH_ERROR;
            end
         endcase

         if (phase_in == PH_ERROR) begin
            cons_c   = 1'b0;
            valid_c  = 1'b0;
            status_c = ST_ERR;
         end else if (phase_in == PH_DONE) begin
            status_c = ST_DONE;
         end
      end

      result_c.body_valid = valid_c;
      result_c.body_byte  = valid_c ? req_data_byte : 8'd0;
      result_c.consumed   = cons_c;
      result_c.status     = status_c;
   end

   // hold decoder state, advance on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SIZE;
         chunk_rem_ff    <= '0;
         length_count_ff <= 32'd0;
         line_empty_ff   <= 1'b1;
         pending_cr_ff   <= 1'b0;
      end else if (req_xfer) begin
         phase_ff        <= phase_in;
         chunk_rem_ff    <= chunk_rem_in;
         length_count_ff <= length_count_in;
         line_empty_ff   <= line_empty_in;
         pending_cr_ff   <= pending_cr_in;
      end
   end

   // steer results into the output register or the skid
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_xfer) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result_c;
            out_valid_in = req_xfer;
         end
      end else if (req_xfer) begin
         skid_in       = result_c;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_body_valid = out_ff.body_valid;
   assign rsp_body_byte  = out_ff.body_byte;
   assign rsp_consumed   = out_ff.consumed;
   assign rsp_status     = out_ff.status;

   // skid is only used behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // a stalled result with a full skid must not be overwritten
   a_skid_held: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(skid_ff)))
      else $error("skid result changed while the output was stalled");

   // a data byte is always part of the body
   a_data_consumed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_body_valid) |-> (rsp_consumed && rsp_status != ST_ERR))
      else $error("body byte reported without being consumed");

   // framing error is sticky until restart
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_restart && chunked_mode_ff && phase_ff == PH_ERROR)
      |=> (phase_ff == PH_ERROR))
      else $error("decoder left the error phase without restart");

endmodule

`default_nettype wire
